/* sv/lcel_pkg.sv */
// ----------------------------------------------------------------------------
// lcel_pkg
// Shared constants, types and helpers for the line change event logger.
// ----------------------------------------------------------------------------
package lcel_pkg;

   // Sizes of the line bank, the event ring and the command queue
   localparam int LINE_COUNT  = 16;
   localparam int RING_DEPTH  = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam int RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int RING_CW  = $clog2(RING_DEPTH + 1);
   localparam int LINE_AW  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   // Field widths of the item and result beats
   localparam int OPC_W  = 2;
   localparam int BITS_W = 16;
   localparam int SEC_W  = 32;
   localparam int SEQ_W  = 16;
   localparam int LINE_W = 4;

   typedef enum logic [OPC_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_NEXT   = 2'd1,
      OP_STATUS = 2'd2
   } opcode_type;

   // Classified command handed from the front to the back
   typedef struct packed {
      opcode_type              opcode;
      logic [LINE_COUNT-1:0]   changes;
      logic [LINE_COUNT-1:0]   bits;
      logic [SEC_W-1:0]        seconds;
      logic [SEQ_W-1:0]        seq;
      logic [LINE_W-1:0]       line;
   } cmd_type;

   // One stored ring event
   typedef struct packed {
      logic [SEC_W-1:0]  seconds;
      logic [SEQ_W-1:0]  seq;
      logic [LINE_W-1:0] line;
      logic              value;
   } ring_entry_type;

   // One result beat
   typedef struct packed {
      logic [SEC_W-1:0]  seconds;
      logic [SEQ_W-1:0]  seq;
      logic [LINE_W-1:0] line;
      logic              value;
      logic              found;
      logic              last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_QUERY,
      ST_QDONE,
      ST_STATUS
   } back_state_type;

   // Advance a ring pointer with wrap
   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] ptr);
      if (ptr == RING_AW'(RING_DEPTH - 1)) begin
         return '0;
      end
      return ptr + RING_AW'(1);
   endfunction

endpackage

/* sv/line_change_event_logger.sv */
// ----------------------------------------------------------------------------
// line_change_event_logger
// Timestamped change logger for a bank of input lines with an event ring.
// ----------------------------------------------------------------------------
// Request channel (req_*): one beat per item; opcode 0 samples the lines,
// opcode 1 asks for the next event after (second, sequence), opcode 2 asks
// for a line's last event time and level. Opcode 3 and samples without a
// change are consumed and give no result beat.
// Result channel (rsp_*): one beat per event of a sample (up to one per line,
// low line first), exactly one beat per query; rsp_last marks the final beat.
// Config channel (csr_*): writes boot_time; csr_ready is always high.
// A sample gives its beats one per cycle while rsp_stall is low; a next-event
// query walks the ring through its single read port, one entry per cycle,
// over every ring entry in the worst case.
// Throughput is set by the back end working one command at a time; the
// two-entry command queue lets req accept while the back end is busy.
// Reset clears line history, ring valid bits and pointers at once, with no
// clearing pass. A stalled result holds in the output register while the
// back end waits; the queue then fills and req_stall rises.
// ----------------------------------------------------------------------------
module line_change_event_logger
   import lcel_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPC_W-1:0]     req_opcode,
   input  logic [BITS_W-1:0]    req_line_bits,
   input  logic [SEC_W-1:0]     req_time_seconds,
   input  logic [SEQ_W-1:0]     req_query_seq,
   input  logic [LINE_W-1:0]    req_line_index,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SEC_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SEC_W-1:0]     rsp_event_seconds,
   output logic [SEQ_W-1:0]     rsp_event_seq,
   output logic [LINE_W-1:0]    rsp_event_line,
   output logic                 rsp_event_value,
   output logic                 rsp_found,
   output logic                 rsp_last
);

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   lcel_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_line_bits    (req_line_bits),
      .req_time_seconds (req_time_seconds),
      .req_query_seq    (req_query_seq),
      .req_line_index   (req_line_index),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   lcel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lcel_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_seconds (rsp_event_seconds),
      .rsp_event_seq     (rsp_event_seq),
      .rsp_event_line    (rsp_event_line),
      .rsp_event_value   (rsp_event_value),
      .rsp_found         (rsp_found),
      .rsp_last          (rsp_last)
   );

endmodule

/* sv/lcel_front.sv */
// ----------------------------------------------------------------------------
// lcel_front
// Accepts request beats, tracks the previous line levels and classifies each
// item into a command for the back end; drops items that give no result.
// ----------------------------------------------------------------------------
module lcel_front
   import lcel_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPC_W-1:0]     req_opcode,
   input  logic [BITS_W-1:0]    req_line_bits,
   input  logic [SEC_W-1:0]     req_time_seconds,
   input  logic [SEQ_W-1:0]     req_query_seq,
   input  logic [LINE_W-1:0]    req_line_index,
   input  logic                 queue_full,
   output logic                 push_valid,
   output cmd_type              push_cmd
);

   logic [LINE_COUNT-1:0] prev_lines_ff;
   logic [LINE_COUNT-1:0] prev_lines_in;
   logic [LINE_COUNT-1:0] bits_masked;
   logic [LINE_COUNT-1:0] changes;
   logic                  accept;
   logic                  keep;

   // Stall while the queue has no room
   assign req_stall   = queue_full;
   assign accept      = req_valid && !req_stall;
   assign bits_masked = req_line_bits[LINE_COUNT-1:0];
   assign changes     = bits_masked ^ prev_lines_ff;

   // Classify: keep samples with a change and both query kinds
   always_comb begin
      keep          = 1'b0;
      prev_lines_in = prev_lines_ff;
      case (opcode_type'(req_opcode))
         OP_SAMPLE: begin
            keep = (changes != '0);
            if (accept) begin
               prev_lines_in = bits_masked;
            end
         end
         OP_NEXT:   keep = 1'b1;
         OP_STATUS: keep = 1'b1;
         default:   keep = 1'b0;
      endcase
   end

   always_comb begin
      push_valid       = accept && keep;
      push_cmd.opcode  = opcode_type'(req_opcode);
      push_cmd.changes = changes;
      push_cmd.bits    = bits_masked;
      push_cmd.seconds = req_time_seconds;
      push_cmd.seq     = req_query_seq;
      push_cmd.line    = req_line_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_lines_ff <= '0;
      end else begin
         prev_lines_ff <= prev_lines_in;
      end
   end

endmodule

/* sv/lcel_queue.sv */
// ----------------------------------------------------------------------------
// lcel_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lcel_queue
   import lcel_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    queue_full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_CW-1:0]   count_ff;
   logic [QUEUE_CW-1:0]   count_in;
   logic                  do_push;
   logic                  do_pop;

   assign queue_full = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + QUEUE_AW'(1);
         end
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/lcel_back.sv */
// ----------------------------------------------------------------------------
// lcel_back
// Executes commands: writes sample events to the ring and line stores, walks
// the ring for next-event queries, reads line status, and drives the result
// output register.
// ----------------------------------------------------------------------------
module lcel_back
   import lcel_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  cmd_type              head_cmd,
   output logic                 pop,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SEC_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SEC_W-1:0]     rsp_event_seconds,
   output logic [SEQ_W-1:0]     rsp_event_seq,
   output logic [LINE_W-1:0]    rsp_event_line,
   output logic                 rsp_event_value,
   output logic                 rsp_found,
   output logic                 rsp_last
);

   back_state_type        state_ff;
   back_state_type        state_in;
   cmd_type               cmd_ff;
   logic [LINE_COUNT-1:0] rem_ff;
   logic [LINE_COUNT-1:0] rem_in;
   logic [RING_AW-1:0]    wp_ff;
   logic [SEC_W-1:0]      newest_sec_ff;
   logic [SEQ_W-1:0]      newest_seq_ff;
   logic [SEC_W-1:0]      boot_time_ff;

   ring_entry_type        ring_mem [RING_DEPTH];
   logic                  ring_vld_ff [RING_DEPTH];
   ring_entry_type        ring_rd_ff;
   logic                  ring_vld_rd_ff;
   logic [RING_AW-1:0]    q_addr_ff;
   logic [RING_CW-1:0]    q_cnt_ff;
   logic                  rd_pend_ff;
   logic                  rd_final_ff;
   result_type            hold_ff;

   logic [SEC_W-1:0]      line_time_ff [LINE_COUNT];
   logic                  line_has_ff  [LINE_COUNT];
   logic                  line_val_ff  [LINE_COUNT];

   result_type            rsp_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic                  out_free;
   logic [LINE_AW-1:0]    pick;
   logic                  sample_last;
   logic [SEQ_W-1:0]      seq_new;
   logic                  pick_value;
   logic [RING_AW-1:0]    wr_addr;
   ring_entry_type        ring_wdata;
   logic                  issue;
   logic                  hit;
   logic                  query_done;
   logic                  line_ok;
   logic [LINE_AW-1:0]    status_idx;

   logic                  emit;
   result_type            emit_data;
   logic                  ring_we;
   logic                  hold_we;
   result_type            hold_data;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Pick the lowest changed line still pending
   always_comb begin
      pick = '0;
      for (int i = LINE_COUNT - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            pick = LINE_AW'(i);
         end
      end
   end

   // Sample event fields
   assign sample_last = ((rem_ff & (rem_ff - LINE_COUNT'(1))) == '0);
   assign seq_new     = (newest_sec_ff == cmd_ff.seconds) ? newest_seq_ff + SEQ_W'(1) : '0;
   assign pick_value  = cmd_ff.bits[pick];
   assign wr_addr     = ring_next(wp_ff);

   always_comb begin
      ring_wdata.seconds = cmd_ff.seconds;
      ring_wdata.seq     = seq_new;
      ring_wdata.line    = LINE_W'(pick);
      ring_wdata.value   = pick_value;
   end

   // Query walk compare
   assign issue = (q_cnt_ff != RING_CW'(RING_DEPTH));
   assign hit   = ring_vld_rd_ff &&
                  ((ring_rd_ff.seconds > cmd_ff.seconds) ||
                   ((ring_rd_ff.seconds == cmd_ff.seconds) && (ring_rd_ff.seq > cmd_ff.seq)));
   assign query_done = rd_pend_ff && (hit || rd_final_ff);

   // Status lookup
   assign line_ok    = ({1'b0, cmd_ff.line} < (LINE_W + 1)'(LINE_COUNT));
   assign status_idx = cmd_ff.line[LINE_AW-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head_cmd.opcode)
                  OP_SAMPLE: state_in = ST_SAMPLE;
                  OP_NEXT:   state_in = ST_QUERY;
                  OP_STATUS: state_in = ST_STATUS;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SAMPLE: begin
            if (out_free && sample_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (query_done) begin
               state_in = ST_QDONE;
            end
         end
         ST_QDONE, ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control strobes and result data
   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_data = '0;
      ring_we   = 1'b0;
      hold_we   = 1'b0;
      hold_data = '0;
      case (state_ff)
         ST_IDLE: pop = head_valid;
         ST_SAMPLE: begin
            if (out_free) begin
               emit              = 1'b1;
               ring_we           = 1'b1;
               emit_data.seconds = cmd_ff.seconds;
               emit_data.seq     = seq_new;
               emit_data.line    = LINE_W'(pick);
               emit_data.value   = pick_value;
               emit_data.found   = 1'b1;
               emit_data.last    = sample_last;
            end
         end
         ST_QUERY: begin
            if (query_done) begin
               hold_we        = 1'b1;
               hold_data.last = 1'b1;
               if (hit) begin
                  hold_data.seconds = ring_rd_ff.seconds;
                  hold_data.seq     = ring_rd_ff.seq;
                  hold_data.line    = ring_rd_ff.line;
                  hold_data.value   = ring_rd_ff.value;
                  hold_data.found   = 1'b1;
               end
            end
         end
         ST_QDONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = hold_ff;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_data.seconds = boot_time_ff;
               emit_data.line    = cmd_ff.line;
               emit_data.found   = 1'b1;
               emit_data.last    = 1'b1;
               if (line_ok && line_has_ff[status_idx]) begin
                  emit_data.seconds = line_time_ff[status_idx];
                  emit_data.value   = line_val_ff[status_idx];
               end
            end
         end
         default: pop = 1'b0;
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      if (pop) begin
         rem_in = head_cmd.changes;
      end else if (ring_we) begin
         rem_in = rem_ff & (rem_ff - LINE_COUNT'(1));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         newest_sec_ff <= '0;
         newest_seq_ff <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         boot_time_ff  <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_vld_ff[i] <= 1'b0;
         end
         for (int i = 0; i < LINE_COUNT; i++) begin
            line_has_ff[i] <= 1'b0;
            line_val_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= (state_ff == ST_QUERY) && issue;
         if (csr_valid && csr_ready) begin
            boot_time_ff <= csr_wdata;
         end
         if (ring_we) begin
            wp_ff                <= wr_addr;
            newest_sec_ff        <= cmd_ff.seconds;
            newest_seq_ff        <= seq_new;
            ring_vld_ff[wr_addr] <= 1'b1;
            line_has_ff[pick]    <= 1'b1;
            line_val_ff[pick]    <= pick_value;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      rd_final_ff <= (q_cnt_ff == RING_CW'(RING_DEPTH - 1));
      if (pop) begin
         cmd_ff    <= head_cmd;
         q_addr_ff <= ring_next(wp_ff);
         q_cnt_ff  <= '0;
      end else if ((state_ff == ST_QUERY) && issue) begin
         q_addr_ff <= ring_next(q_addr_ff);
         q_cnt_ff  <= q_cnt_ff + RING_CW'(1);
      end
      if (ring_we) begin
         line_time_ff[pick] <= cmd_ff.seconds;
      end
      if (hold_we) begin
         hold_ff <= hold_data;
      end
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   // Event ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wr_addr] <= ring_wdata;
      end
      ring_rd_ff     <= ring_mem[q_addr_ff];
      ring_vld_rd_ff <= ring_vld_ff[q_addr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_seconds = rsp_ff.seconds;
   assign rsp_event_seq     = rsp_ff.seq;
   assign rsp_event_line    = rsp_ff.line;
   assign rsp_event_value   = rsp_ff.value;
   assign rsp_found         = rsp_ff.found;
   assign rsp_last          = rsp_ff.last;

endmodule

/* sv/lcel_checker.sv */
// ----------------------------------------------------------------------------
// lcel_checker
// Port-level checks on the line change event logger, bound to the top level.
// ----------------------------------------------------------------------------
module lcel_checker
   import lcel_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [SEC_W-1:0]     rsp_event_seconds,
   input  logic [SEQ_W-1:0]     rsp_event_seq,
   input  logic [LINE_W-1:0]    rsp_event_line,
   input  logic                 rsp_event_value,
   input  logic                 rsp_found,
   input  logic                 rsp_last
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_seconds) &&
      $stable(rsp_event_seq) && $stable(rsp_event_line) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // Drop any result beat after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A missed query reports all-zero fields and ends the item
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && (rsp_event_seconds == '0) &&
      (rsp_event_seq == '0) && (rsp_event_line == '0) && !rsp_event_value)
      else $error("missed query with nonzero fields");

   // Only sample events come in multi-beat bursts, and they are always found
   a_burst_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_found)
      else $error("non-final beat without found");

endmodule

bind line_change_event_logger lcel_checker u_checker (.*);

/* test/line_change_event_logger_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_change_event_logger_tb
// Self-checking bench for the line change event logger. A queue-fed driver
// sends sample, next-event and status requests with random gaps. A monitor
// stalls the result channel at random and checks every result beat against a
// local model of the event ring and the per-line history. The run covers
// several boot_time settings and a burst within one second that wraps the ring.
// ----------------------------------------------------------------------------
module line_change_event_logger_tb
   import lcel_pkg::*;
();

   localparam int                CLK_PERIOD    = 4;
   localparam int                RESET_CYCLES  = 7;
   localparam int                CYCLE_LIMIT   = 1000000;
   localparam int                DRAIN_CYCLES  = RING_DEPTH + 32;
   localparam int                RANDOM_ITEMS  = 50;
   localparam int                BURST_SAMPLES = 8;
   localparam logic [OPC_W-1:0]  OP_UNUSED     = 2'd3;
   localparam logic [BITS_W-1:0] LINE_MASK     = (LINE_COUNT >= BITS_W) ?
      {BITS_W{1'b1}} : BITS_W'((1 << LINE_COUNT) - 1);

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [BITS_W-1:0] bits;
      logic [SEC_W-1:0]  seconds;
      logic [SEQ_W-1:0]  seq;
      logic [LINE_W-1:0] line;
   } request_beat_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [OPC_W-1:0]    req_opcode       = '0;
   logic [BITS_W-1:0]   req_line_bits    = '0;
   logic [SEC_W-1:0]    req_time_seconds = '0;
   logic [SEQ_W-1:0]    req_query_seq    = '0;
   logic [LINE_W-1:0]   req_line_index   = '0;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [SEC_W-1:0]    csr_wdata        = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [SEC_W-1:0]    rsp_event_seconds;
   logic [SEQ_W-1:0]    rsp_event_seq;
   logic [LINE_W-1:0]   rsp_event_line;
   logic                rsp_event_value;
   logic                rsp_found;
   logic                rsp_last;

   // Requests waiting to be sent and event beats the logger still owes
   request_beat_type    queued_requests[$];
   result_type          due_events[$];
   request_beat_type    held_request;

   // Local copy of the logger state
   logic [SEC_W-1:0]    boot_seconds;
   logic [BITS_W-1:0]   seen_levels;
   int                  ring_head;
   ring_entry_type      ring_store[RING_DEPTH];
   logic [SEC_W-1:0]    line_stamp[LINE_COUNT];
   logic                line_logged[LINE_COUNT];
   logic                line_level[LINE_COUNT];

   // Pacing of both channels
   int                  gap_left     = 0;
   int                  stall_left   = 0;
   bit                  req_burst    = 1'b0;
   bit                  rsp_burst    = 1'b0;
   bit                  hold_no_idle = 1'b0;
   int                  fail_count   = 0;
   int                  cycle_count  = 0;

   // Stimulus generator history
   logic [BITS_W-1:0]   gen_lines = '0;
   logic [SEC_W-1:0]    gen_sec   = '0;
   logic [SEC_W-1:0]    used_secs[$];

   line_change_event_logger DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_line_bits     (req_line_bits),
      .req_time_seconds  (req_time_seconds),
      .req_query_seq     (req_query_seq),
      .req_line_index    (req_line_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_seconds (rsp_event_seconds),
      .rsp_event_seq     (rsp_event_seq),
      .rsp_event_line    (rsp_event_line),
      .rsp_event_value   (rsp_event_value),
      .rsp_found         (rsp_found),
      .rsp_last          (rsp_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Clear the local logger state
   task automatic clear_logger_state();
      boot_seconds = '0;
      seen_levels  = '0;
      ring_head    = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring_store[i] = '0;
      end
      for (int i = 0; i < LINE_COUNT; i++) begin
         line_stamp[i]  = '0;
         line_logged[i] = 1'b0;
         line_level[i]  = 1'b0;
      end
      due_events.delete();
   endtask

   // Apply one accepted request to the local state and queue the beats it owes
   task automatic advance_logger_state(input request_beat_type b);
      logic [BITS_W-1:0] levels;
      logic [BITS_W-1:0] changes;
      logic [SEQ_W-1:0]  run_seq;
      bit                chained;
      bit                hit;
      int                top_line;
      int                idx;
      ring_entry_type    ent;
      result_type        r;
      levels = b.bits & LINE_MASK;
      r      = '0;
      case (b.opcode)
         OP_SAMPLE: begin
            changes     = levels ^ seen_levels;
            chained     = (ring_store[ring_head].seconds == b.seconds);
            run_seq     = ring_store[ring_head].seq;
            seen_levels = levels;
            top_line    = -1;
            for (int i = 0; i < LINE_COUNT; i++) begin
               if (changes[i]) top_line = i;
            end
            // Log each changed line, low line first
            for (int i = 0; i < LINE_COUNT; i++) begin
               if (changes[i]) begin
                  run_seq     = chained ? run_seq + SEQ_W'(1) : '0;
                  chained     = 1'b1;
                  ring_head   = (ring_head + 1) % RING_DEPTH;
                  ent.seconds = b.seconds;
                  ent.seq     = run_seq;
                  ent.line    = LINE_W'(i);
                  ent.value   = levels[i];
                  ring_store[ring_head] = ent;
                  line_stamp[i]  = b.seconds;
                  line_logged[i] = 1'b1;
                  line_level[i]  = levels[i];
                  r.seconds = ent.seconds;
                  r.seq     = ent.seq;
                  r.line    = ent.line;
                  r.value   = ent.value;
                  r.found   = 1'b1;
                  r.last    = (i == top_line);
                  due_events.push_back(r);
               end
            end
         end
         OP_NEXT: begin
            // Walk from oldest to newest, take the first strictly later event
            hit = 1'b0;
            for (int k = 1; k <= RING_DEPTH; k++) begin
               idx = (ring_head + k) % RING_DEPTH;
               if (!hit && (ring_store[idx].seconds > b.seconds ||
                            (ring_store[idx].seconds == b.seconds &&
                             ring_store[idx].seq > b.seq))) begin
                  hit     = 1'b1;
                  r.seconds = ring_store[idx].seconds;
                  r.seq     = ring_store[idx].seq;
                  r.line    = ring_store[idx].line;
                  r.value   = ring_store[idx].value;
               end
            end
            r.found = hit;
            r.last  = 1'b1;
            due_events.push_back(r);
         end
         OP_STATUS: begin
            r.seconds = boot_seconds;
            r.line    = b.line;
            r.found   = 1'b1;
            r.last    = 1'b1;
            if (b.line < LINE_COUNT && line_logged[b.line]) begin
               r.seconds = line_stamp[b.line];
               r.value   = line_level[b.line];
            end
            due_events.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   function automatic int draw_req_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) req_burst = ~req_burst;
      if (hold_no_idle || req_burst) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int draw_rsp_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) rsp_burst = ~rsp_burst;
      if (hold_no_idle || rsp_burst) return 0;
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Request driver: predict on every accepted beat, then load the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_logger_state();
      end else begin
         if (req_valid && !req_stall) begin
            advance_logger_state(held_request);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || queued_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               held_request = queued_requests.pop_front();
               req_opcode       <= held_request.opcode;
               req_line_bits    <= held_request.bits;
               req_time_seconds <= held_request.seconds;
               req_query_seq    <= held_request.seq;
               req_line_index   <= held_request.line;
               req_valid        <= 1'b1;
               gap_left = draw_req_gap();
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp,
                                       input logic [31:0] act);
      if (exp !== act) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      end
   endfunction

   // Result monitor: check each accepted beat, then pick the next stall
   always @(posedge clock) begin
      result_type exp_beat;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_events.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected beat, expected none, actual sec %0h seq %0h line %0h",
                        $time, rsp_event_seconds, rsp_event_seq, rsp_event_line);
            end else begin
               exp_beat = due_events.pop_front();
               check_field("event_seconds", exp_beat.seconds, rsp_event_seconds);
               check_field("event_seq", 32'(exp_beat.seq), 32'(rsp_event_seq));
               check_field("event_line", 32'(exp_beat.line), 32'(rsp_event_line));
               check_field("event_value", 32'(exp_beat.value), 32'(rsp_event_value));
               check_field("found", 32'(exp_beat.found), 32'(rsp_found));
               check_field("last", 32'(exp_beat.last), 32'(rsp_last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = draw_rsp_stall();
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Random fillers for fields an item does not use
   function automatic logic [BITS_W-1:0] rnd_bits();
      return BITS_W'($urandom);
   endfunction

   function automatic logic [SEQ_W-1:0] rnd_seq();
      return SEQ_W'($urandom);
   endfunction

   function automatic logic [LINE_W-1:0] rnd_line();
      return LINE_W'($urandom);
   endfunction

   task automatic push_item(input logic [OPC_W-1:0] op, input logic [BITS_W-1:0] bits,
                            input logic [SEC_W-1:0] sec, input logic [SEQ_W-1:0] seq,
                            input logic [LINE_W-1:0] line);
      request_beat_type b;
      b.opcode  = op;
      b.bits    = bits;
      b.seconds = sec;
      b.seq     = seq;
      b.line    = line;
      queued_requests.push_back(b);
   endtask

   // Wait until every request is sent and every beat is back, then settle
   task automatic wait_idle();
      while (queued_requests.size() != 0 || req_valid || due_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_boot_time(input logic [SEC_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      boot_seconds = value;
      csr_valid <= 1'b0;
   endtask

   task automatic push_random_item();
      int                r;
      int                k;
      logic [BITS_W-1:0] bits;
      logic [SEC_W-1:0]  sec;
      logic [SEQ_W-1:0]  q;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         // Sample: mostly a few flipped lines, mostly the same or next second
         k = $urandom_range(0, 99);
         bits = gen_lines;
         if (k < 70) begin
            repeat ($urandom_range(1, 3)) begin
               k = $urandom_range(0, BITS_W - 1);
               bits[k] = ~bits[k];
            end
         end else if (k < 85) begin
            bits = rnd_bits();
         end
         k = $urandom_range(0, 99);
         sec = (k < 50) ? gen_sec : (k < 85) ? gen_sec + 1 : $urandom;
         gen_lines = bits;
         gen_sec   = sec;
         used_secs.push_back(sec);
         push_item(OP_SAMPLE, bits, sec, rnd_seq(), rnd_line());
      end else if (r < 75) begin
         // Next-event query, mostly around seconds already logged
         if (used_secs.size() > 0 && $urandom_range(0, 9) < 7) begin
            sec = used_secs[$urandom_range(0, used_secs.size() - 1)] - $urandom_range(0, 1);
         end else begin
            sec = $urandom;
         end
         q = ($urandom_range(0, 9) < 6) ? SEQ_W'($urandom_range(0, 20)) : rnd_seq();
         push_item(OP_NEXT, rnd_bits(), sec, q, rnd_line());
      end else if (r < 95) begin
         push_item(OP_STATUS, rnd_bits(), $urandom, rnd_seq(), rnd_line());
      end else begin
         push_item(OP_UNUSED, rnd_bits(), $urandom, rnd_seq(), rnd_line());
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty history, full bank toggles, boundaries of time
      write_boot_time(32'hFFFF_FFFF);
      push_item(OP_STATUS, rnd_bits(), $urandom, rnd_seq(), 4'd0);
      push_item(OP_STATUS, rnd_bits(), $urandom, rnd_seq(), 4'd15);
      push_item(OP_NEXT, rnd_bits(), 32'd0, 16'd0, rnd_line());
      push_item(OP_SAMPLE, 16'hFFFF, 32'd5, rnd_seq(), rnd_line());
      push_item(OP_SAMPLE, 16'hFFFF, 32'd5, rnd_seq(), rnd_line());
      push_item(OP_SAMPLE, 16'h0000, 32'd5, rnd_seq(), rnd_line());
      push_item(OP_SAMPLE, 16'h8001, 32'd6, rnd_seq(), rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'd0, 16'd0, rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'd5, 16'd3, rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'd5, 16'd31, rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'd6, 16'd1, rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'hFFFF_FFFF, 16'hFFFF, rnd_line());
      push_item(OP_STATUS, rnd_bits(), $urandom, rnd_seq(), 4'd0);
      push_item(OP_STATUS, rnd_bits(), $urandom, rnd_seq(), 4'd15);
      push_item(OP_STATUS, rnd_bits(), $urandom, rnd_seq(), 4'd7);
      push_item(OP_UNUSED, rnd_bits(), $urandom, rnd_seq(), rnd_line());
      push_item(OP_SAMPLE, 16'h5555, 32'hFFFF_FFFF, rnd_seq(), rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'hFFFF_FFFE, 16'hFFFF, rnd_line());
      push_item(OP_SAMPLE, 16'hAAAA, 32'hFFFF_FFFF, rnd_seq(), rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'hFFFF_FFFF, 16'd7, rnd_line());
      push_item(OP_SAMPLE, 16'h0000, 32'd0, rnd_seq(), rnd_line());
      push_item(OP_NEXT, rnd_bits(), 32'd0, 16'd0, rnd_line());
      push_item(OP_STATUS, rnd_bits(), $urandom, rnd_seq(), 4'd3);
      gen_lines = 16'h0000;
      gen_sec   = 32'd0;
      used_secs.push_back(32'd5);
      used_secs.push_back(32'd6);
      wait_idle();

      // Random part in two settings of boot_time
      write_boot_time(32'd0);
      repeat (RANDOM_ITEMS) push_random_item();
      wait_idle();
      write_boot_time($urandom);
      repeat (RANDOM_ITEMS) push_random_item();
      wait_idle();

      // Burst of full-bank toggles within one second: the ring wraps around
      write_boot_time($urandom);
      hold_no_idle = 1'b1;
      gen_sec = gen_sec + 32'd1000;
      for (int n = 0; n < BURST_SAMPLES; n++) begin
         gen_lines = ~gen_lines;
         push_item(OP_SAMPLE, gen_lines, gen_sec, rnd_seq(), rnd_line());
      end
      push_item(OP_NEXT, rnd_bits(), gen_sec, 16'd0, rnd_line());
      wait_idle();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* line_change_event_logger.f */
sv/lcel_pkg.sv
sv/lcel_front.sv
sv/lcel_queue.sv
sv/lcel_back.sv
sv/line_change_event_logger.sv
sv/lcel_checker.sv
test/line_change_event_logger_tb.sv
